// ===== rtl/hpf3_pkg.sv =====
`default_nettype none

package hpf3_pkg;

  typedef logic [7:0] pixel_t;
  typedef logic signed [11:0] acc_t;
  typedef logic signed [8:0] result_t;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [10:0] WIDTH_RESET = 11'd256;
  localparam logic [12:0] HEIGHT_RESET = 13'd256;

  // floor(m/9) == (m*1821) >> 14 for every m up to 2040
  localparam logic [10:0] DIV9_RECIP = 11'd1821;
  localparam int DIV9_SHIFT = 14;

endpackage

`default_nettype wire

// ===== rtl/high_pass_filter_3x3_unit.sv =====
`default_nettype none

// 3x3 high-pass filter, (8*centre - sum of the eight neighbours)/9 truncated toward zero,
// over byte pixels in raster order with a zero border. One beat is accepted per clock;
// unless the output stalls with the stage full; a result crosses the stage and output
// registers after the beat completing its window (its lower-right neighbour), so results
// lag the input by image_width+1 beats and the frame is flushed by image_width+1 drain
// beats, after which the position returns to the frame start. Rows live in one
// MAX_WIDTH-entry memory holding both rows, written once per beat; its read is registered
// from the next column. The memory is never cleared: its stale contents sit outside the
// frame and are masked by the border logic. A register write restarts the frame.
module high_pass_filter_3x3_unit
  import hpf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire pixel_t                 pixel,
  input  wire logic                   drain,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      pixel_t                 filtered_pixel,
  output      result_t                filtered_signed,
  output      logic                   last_pixel
);

  localparam int KW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // configuration
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] eff_h_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == 11'd0) begin
      eff_w = WW'(1);
    end else if ({21'd0, image_width} > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == 13'd0) begin
      eff_h = HW'(1);
    end else if ({19'd0, image_height} > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
    eff_h_r = RW'(eff_h);
  end

  // handshake
  logic in_acc;
  logic st_valid;
  logic adv_out;

  assign adv_out = !out_valid || out_ready;
  assign in_ready = !st_valid || adv_out;
  assign in_acc = in_valid && in_ready;

  // position: column and row of the incoming beat
  logic [KW-1:0] column_count, column_count_next;
  logic [RW-1:0] in_row, in_row_next;
  logic col_wrap;
  logic frame_end;
  logic in_frame;
  logic produced;

  assign col_wrap = (WW'(column_count) + WW'(1)) == eff_w;
  assign frame_end = (in_row == eff_h_r + RW'(1)) && (column_count == '0);
  assign in_frame = in_row < eff_h_r;
  assign produced = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (column_count != '0));

  always_comb begin
    column_count_next = column_count;
    in_row_next = in_row;
    if (cfg_we) begin
      column_count_next = '0;
      in_row_next = '0;
    end else if (in_acc) begin
      if (frame_end) begin
        column_count_next = '0;
        in_row_next = '0;
      end else if (col_wrap) begin
        column_count_next = '0;
        in_row_next = in_row + RW'(1);
      end else begin
        column_count_next = column_count + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      in_row <= '0;
    end else begin
      column_count <= column_count_next;
      in_row <= in_row_next;
    end
  end

  // row store: [15:8] older row, [7:0] newer row
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] line_rd;
  logic [15:0] line_wr;
  logic [KW-1:0] rd_addr;
  pixel_t col_up, col_mid, col_down;

  assign col_up = line_rd[15:8];
  assign col_mid = line_rd[7:0];
  assign col_down = (drain || !in_frame) ? 8'd0 : pixel;
  assign line_wr = {col_mid, col_down};
  assign rd_addr = rst ? '0 : column_count_next;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[column_count] <= line_wr;
    end
    // write-first bypass when the column being written is read next, as in a one-column frame
    if (in_acc && (rd_addr == column_count)) begin
      line_rd <= line_wr;
    end else begin
      line_rd <= line_mem[rd_addr];
    end
  end

  // window taps, left and centre columns only
  pixel_t win_ul, win_uc, win_ml, win_mc, win_dl, win_dc;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_ul <= '0;
      win_uc <= '0;
      win_ml <= '0;
      win_mc <= '0;
      win_dl <= '0;
      win_dc <= '0;
    end else if (in_acc) begin
      win_ul <= win_uc;
      win_uc <= col_up;
      win_ml <= win_mc;
      win_mc <= col_mid;
      win_dl <= win_dc;
      win_dc <= col_down;
    end
  end

  // border flags of the pixel whose window completes now
  logic [RW-1:0] q_row;
  logic [WW-1:0] q_col;
  logic has_up, has_down, has_left, has_right;
  logic q_last;
  logic [10:0] nb_sum;
  acc_t acc;

  always_comb begin
    if (column_count == '0) begin
      q_row = in_row - RW'(2);
      q_col = eff_w - WW'(1);
    end else begin
      q_row = in_row - RW'(1);
      q_col = WW'(column_count) - WW'(1);
    end
    has_up = q_row != '0;
    has_down = (q_row + RW'(1)) < eff_h_r;
    has_left = q_col != '0;
    has_right = (q_col + WW'(1)) < eff_w;
    q_last = !has_down && !has_right;

    nb_sum = (has_up ? 11'(win_uc) : 11'd0)
           + (has_down ? 11'(win_dc) : 11'd0)
           + (has_left ? 11'(win_ml) : 11'd0)
           + ((has_left && has_up) ? 11'(win_ul) : 11'd0)
           + ((has_left && has_down) ? 11'(win_dl) : 11'd0)
           + (has_right ? 11'(col_mid) : 11'd0)
           + ((has_right && has_up) ? 11'(col_up) : 11'd0)
           + ((has_right && has_down) ? 11'(col_down) : 11'd0);
    acc = $signed({1'b0, win_mc, 3'b000}) - $signed({1'b0, nb_sum});
  end

  // stage register
  acc_t st_acc;
  logic st_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_acc) begin
      st_valid <= produced;
    end else if (adv_out) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_acc <= acc;
      st_last <= q_last;
    end
  end

  // divide by nine on the magnitude, then restore the sign
  logic st_neg;
  logic [10:0] st_mag;
  logic [21:0] div_prod;
  pixel_t quo;
  result_t val;

  always_comb begin
    st_neg = st_acc[11];
    st_mag = st_neg ? 11'(-st_acc) : st_acc[10:0];
    div_prod = 22'(st_mag) * 22'(DIV9_RECIP);
    quo = div_prod[DIV9_SHIFT +: 8];
    val = st_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && st_valid) begin
      filtered_signed <= val;
      filtered_pixel <= st_neg ? 8'd0 : quo;
      last_pixel <= st_last;
    end
  end

`ifndef SYNTHESIS
  a_clamp_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (filtered_signed[8] ? (filtered_pixel == 8'd0)
                                      : (filtered_pixel == filtered_signed[7:0])))
    else $error("clamped pixel disagrees with signed result");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((filtered_signed <= 9'sd226) && (filtered_signed >= -9'sd226)))
    else $error("filter result outside its range");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    (WW'(column_count) < eff_w) && (in_row <= eff_h_r + RW'(1)))
    else $error("position counters beyond the frame");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (st_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (st_valid && adv_out && !in_acc) |=> out_valid && !st_valid)
    else $error("stage result lost on its way to the output");
`endif

endmodule

`default_nettype wire
